### hw/rtl/cpo_pkg.sv
// Shared types and constants for the circle pair overlap test.
// No dependencies; used by every module in hw/rtl.
package cpo_pkg;

    localparam int unsigned TAG_W   = 20;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned RAD_W   = 30;
    localparam int unsigned MAG_W   = 31;  // |dx|, |dy| below 2^31 when near
    localparam int unsigned ROOT_W  = 32;
    localparam int unsigned QUO_W   = 31;
    localparam logic [63:0] EPS_Q32 = 64'd429;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PAIR  = 1'b1;

    // Per-pair data carried alongside the sqrt and divider pipelines
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             hit;
        logic [RAD_W:0]   rad;
        logic             sx;
        logic             sy;
        logic [MAG_W-1:0] adx;
        logic [MAG_W-1:0] ady;
    } side_t;

endpackage

### hw/rtl/cpo_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
// Depends on cpo_pkg (side_t, ROOT_W).
module cpo_sqrt_pipe import cpo_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  logic [63:0]       in_val,
    output logic              out_valid,
    output side_t             out_side,
    output logic [ROOT_W-1:0] out_root
);

    logic              v_reg    [ROOT_W+1];
    side_t             side_reg [ROOT_W+1];
    logic [63:0]       val_reg  [ROOT_W+1];
    logic [ROOT_W:0]   rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];

    always_comb begin
        v_reg[0]    = in_valid;
        side_reg[0] = in_side;
        val_reg[0]  = in_val;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
    end

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic [ROOT_W+2:0] r2;
        logic [ROOT_W+2:0] trial;
        logic              take;

        always_comb begin
            r2    = {rem_reg[i], val_reg[i][63:62]};
            trial = {1'b0, root_reg[i], 2'b01};
            take  = (r2 >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                side_reg[i+1] <= side_reg[i];
                val_reg[i+1]  <= {val_reg[i][61:0], 2'b00};
                if (take) begin
                    rem_reg[i+1]  <= (ROOT_W+1)'(r2 - trial);
                    root_reg[i+1] <= {root_reg[i][ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[i+1]  <= r2[ROOT_W:0];
                    root_reg[i+1] <= {root_reg[i][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];

endmodule

### hw/rtl/cpo_div_pipe.sv
// Pipelined restoring divider for both normal components, one quotient bit per stage.
// Depends on cpo_pkg (side_t, widths).
module cpo_div_pipe import cpo_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  logic [ROOT_W-1:0] in_dist,
    output logic              out_valid,
    output side_t             out_side,
    output logic [ROOT_W-1:0] out_dist,
    output logic [QUO_W-1:0]  out_qx,
    output logic [QUO_W-1:0]  out_qy
);

    // Numerator is |d| * 2^30; the top 30 bits are below dist whenever it matters
    logic              v_reg    [QUO_W+1];
    side_t             side_reg [QUO_W+1];
    logic [ROOT_W-1:0] dist_reg [QUO_W+1];
    logic [ROOT_W-1:0] rx_reg   [QUO_W+1];
    logic [ROOT_W-1:0] ry_reg   [QUO_W+1];
    logic [QUO_W-1:0]  nx_reg   [QUO_W+1];
    logic [QUO_W-1:0]  ny_reg   [QUO_W+1];
    logic [QUO_W-1:0]  qx_reg   [QUO_W+1];
    logic [QUO_W-1:0]  qy_reg   [QUO_W+1];

    always_comb begin
        v_reg[0]    = in_valid;
        side_reg[0] = in_side;
        dist_reg[0] = in_dist;
        rx_reg[0]   = {2'b00, in_side.adx[MAG_W-1:1]};
        ry_reg[0]   = {2'b00, in_side.ady[MAG_W-1:1]};
        nx_reg[0]   = {in_side.adx[0], 30'd0};
        ny_reg[0]   = {in_side.ady[0], 30'd0};
        qx_reg[0]   = '0;
        qy_reg[0]   = '0;
    end

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic [ROOT_W:0] tx, ty;
        logic            kx, ky;

        always_comb begin
            tx = {rx_reg[i], nx_reg[i][QUO_W-1]};
            ty = {ry_reg[i], ny_reg[i][QUO_W-1]};
            kx = (tx >= {1'b0, dist_reg[i]});
            ky = (ty >= {1'b0, dist_reg[i]});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                side_reg[i+1] <= side_reg[i];
                dist_reg[i+1] <= dist_reg[i];
                nx_reg[i+1]   <= {nx_reg[i][QUO_W-2:0], 1'b0};
                ny_reg[i+1]   <= {ny_reg[i][QUO_W-2:0], 1'b0};
                rx_reg[i+1]   <= kx ? ROOT_W'(tx - {1'b0, dist_reg[i]}) : tx[ROOT_W-1:0];
                ry_reg[i+1]   <= ky ? ROOT_W'(ty - {1'b0, dist_reg[i]}) : ty[ROOT_W-1:0];
                qx_reg[i+1]   <= {qx_reg[i][QUO_W-2:0], kx};
                qy_reg[i+1]   <= {qy_reg[i][QUO_W-2:0], ky};
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];
    assign out_dist  = dist_reg[QUO_W];
    assign out_qx    = qx_reg[QUO_W];
    assign out_qy    = qy_reg[QUO_W];

endmodule

### hw/rtl/circle_pair_overlap_test.sv
// Top level of the circle pair overlap test: circle table, difference and
// square stages, then the sqrt and divider pipelines. Depends on cpo_pkg,
// cpo_sqrt_pipe and cpo_div_pipe.
//
//  channel | dir | tuser   | tlast      | tdata
//  s_      | in  | kind    | last_pair  | body_a, body_b, pos_x, pos_y, radius, pair_number
//  m_      | out | overlap | batch_end  | pair_tag, penetration, normal_x, normal_y
//
// One item per cycle unless the output stalls; a pair result passes through the table
// read, 3 arithmetic stages, 32 sqrt stages, 31 divider stages and the output register.
// Writes give no result and land in the table in the cycle of their transfer.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears valid bits only; table entries are undefined until written.
module circle_pair_overlap_test import cpo_pkg::*; #(
    parameter int unsigned BODIES    = 1024,
    parameter int unsigned MAX_PAIRS = 1048576
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // body_a, body_b, pos_x, pos_y, radius, pair_number, pad
    input  logic         s_tuser,   // kind
    input  logic         s_tlast,   // last_pair
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // pair_tag, penetration, normal_x, normal_y, pad
    output logic         m_tuser,   // overlap
    output logic         m_tlast    // batch_end
);

    localparam int unsigned AW = (BODIES > 1) ? $clog2(BODIES) : 1;

    logic en;
    logic s_fire;

    logic [9:0]         in_a, in_b;
    logic [31:0]        in_x, in_y;
    logic [RAD_W-1:0]   in_r;
    logic [TAG_W-1:0]   in_pn;
    logic [AW-1:0]      ia, ib;

    assign in_a  = s_tdata[9:0];
    assign in_b  = s_tdata[19:10];
    assign in_x  = s_tdata[51:20];
    assign in_y  = s_tdata[83:52];
    assign in_r  = s_tdata[113:84];
    assign in_pn = s_tdata[133:114];
    assign ia    = AW'(32'(in_a) % BODIES);
    assign ib    = AW'(32'(in_b) % BODIES);

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign s_fire   = s_tvalid && s_tready;

    // Circle table
    logic [31:0]      cx_mem_reg [BODIES];
    logic [31:0]      cy_mem_reg [BODIES];
    logic [RAD_W-1:0] cr_mem_reg [BODIES];

    logic               v1_reg;
    logic [TAG_W-1:0]   tag1_reg;
    logic               last1_reg;
    logic signed [31:0] xa_reg, xb_reg, ya_reg, yb_reg;
    logic [RAD_W-1:0]   ra_reg, rb_reg;

    always_ff @(posedge aclk) begin
        if (s_fire && s_tuser == KIND_WRITE) begin
            cx_mem_reg[ia] <= in_x;
            cy_mem_reg[ia] <= in_y;
            cr_mem_reg[ia] <= in_r;
        end
        if (en) begin
            xa_reg    <= cx_mem_reg[ia];
            xb_reg    <= cx_mem_reg[ib];
            ya_reg    <= cy_mem_reg[ia];
            yb_reg    <= cy_mem_reg[ib];
            ra_reg    <= cr_mem_reg[ia];
            rb_reg    <= cr_mem_reg[ib];
            tag1_reg  <= TAG_W'(32'(in_pn) % MAX_PAIRS);
            last1_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_fire && s_tuser == KIND_PAIR;
        end
    end

    // Stage 2: differences and magnitudes
    logic signed [32:0] dx_next, dy_next;
    logic [32:0]        mx_next, my_next;
    logic               v2_reg, far2_reg;
    side_t              side2_reg;

    always_comb begin
        dx_next = 33'(xb_reg) - 33'(xa_reg);
        dy_next = 33'(yb_reg) - 33'(ya_reg);
        mx_next = dx_next[32] ? 33'(-dx_next) : 33'(dx_next);
        my_next = dy_next[32] ? 33'(-dy_next) : 33'(dy_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            far2_reg       <= (mx_next[32:31] != 2'b00) || (my_next[32:31] != 2'b00);
            side2_reg.tag  <= tag1_reg;
            side2_reg.last <= last1_reg;
            side2_reg.hit  <= 1'b0;
            side2_reg.rad  <= {1'b0, ra_reg} + {1'b0, rb_reg};
            side2_reg.sx   <= dx_next[32];
            side2_reg.sy   <= dy_next[32];
            side2_reg.adx  <= mx_next[MAG_W-1:0];
            side2_reg.ady  <= my_next[MAG_W-1:0];
        end
    end

    // Stage 3: squares
    logic        v3_reg, far3_reg;
    side_t       side3_reg;
    logic [61:0] sx3_reg, sy3_reg, rr3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            far3_reg  <= far2_reg;
            side3_reg <= side2_reg;
            sx3_reg   <= side2_reg.adx * side2_reg.adx;
            sy3_reg   <= side2_reg.ady * side2_reg.ady;
            rr3_reg   <= side2_reg.rad * side2_reg.rad;
        end
    end

    // Stage 4: d2, overlap decision, sqrt operand
    logic [62:0] d2_next;
    side_t       side4_next;
    logic        v4_reg;
    side_t       side4_reg;
    logic [63:0] val4_reg;

    assign d2_next = {1'b0, sx3_reg} + {1'b0, sy3_reg};

    always_comb begin
        side4_next     = side3_reg;
        side4_next.hit = !far3_reg && (d2_next < {1'b0, rr3_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            side4_reg <= side4_next;
            val4_reg  <= {1'b0, d2_next} + EPS_Q32;
        end
    end

    logic              sq_valid;
    side_t             sq_side;
    logic [ROOT_W-1:0] sq_root;

    cpo_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_side   (side4_reg),
        .in_val    (val4_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    logic              dv_valid;
    side_t             dv_side;
    logic [ROOT_W-1:0] dv_dist;
    logic [QUO_W-1:0]  dv_qx, dv_qy;

    cpo_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_dist   (sq_root),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_dist  (dv_dist),
        .out_qx    (dv_qx),
        .out_qy    (dv_qy)
    );

    // Output stage: saturate penetration, apply signs, zero on miss
    logic signed [33:0] pen_wide;
    logic [31:0]        pen_next, nx_next, ny_next;

    always_comb begin
        pen_wide = $signed({3'b000, dv_side.rad}) - $signed({2'b00, dv_dist});
        if (pen_wide < -34'sd2147483648) begin
            pen_next = 32'h8000_0000;
        end else begin
            pen_next = pen_wide[31:0];
        end
        nx_next = dv_side.sx ? 32'(-{1'b0, dv_qx}) : {1'b0, dv_qx};
        ny_next = dv_side.sy ? 32'(-{1'b0, dv_qy}) : {1'b0, dv_qy};
        if (!dv_side.hit) begin
            pen_next = '0;
            nx_next  = '0;
            ny_next  = '0;
        end
    end

    logic [119:0] m_data_reg;
    logic         m_valid_reg, m_user_reg, m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
        if (en) begin
            m_data_reg <= {4'd0, ny_next, nx_next, pen_next, dv_side.tag};
            m_user_reg <= dv_side.hit;
            m_last_reg <= dv_side.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // A miss carries no penetration and no normal
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[115:20] == 96'd0)
        else $error("nonzero payload on a miss");

    // Normal components never take the most negative 32-bit value
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[83:52] != 32'h8000_0000 && m_tdata[115:84] != 32'h8000_0000)
        else $error("normal out of range");

    // No input transfer while a result is held back
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for circle_pair_overlap_test: loads circles, streams pair
// tests and compares every result transfer against an in-bench overlap predictor.
// Depends on cpo_pkg and the circle_pair_overlap_test RTL.
module testbench import cpo_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBODY = 1024;
    localparam int LATENCY = 80;
    localparam int WATCHDOG = 20000;
    localparam int HOLD_LEN = 300;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic [19:0] num;
        logic [29:0] rad;
        logic [31:0] py;
        logic [31:0] px;
        logic [9:0]  bb;
        logic [9:0]  ba;
    } item_t;

    typedef struct {
        logic [19:0] tag;
        logic        hit;
        logic [31:0] pen;
        logic [31:0] nx;
        logic [31:0] ny;
        logic        last;
    } hit_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [135:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    circle_pair_overlap_test uut (.*);

    always #5 aclk = ~aclk;

    item_t pending_items[$];
    hit_t  expected_hits[$];
    logic signed [31:0] cx[NBODY];
    logic signed [31:0] cy[NBODY];
    logic [29:0]        cr[NBODY];
    bit                 loaded[NBODY];
    int  mismatches = 0;
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_recv = 0;
    int  hold_cycles = 0;
    int  quiet = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] rem, res, b;
        rem = v;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Applies one accepted transfer to the circle table and predicts the pair result.
    task automatic predict_overlap(item_t it);
        hit_t h;
        logic signed [63:0] dx, dy, pen, root_d;
        logic [63:0] adx, ady, rad, d2;
        if (it.kind == KIND_WRITE) begin
            cx[it.ba] = it.px;
            cy[it.ba] = it.py;
            cr[it.ba] = it.rad;
            return;
        end
        dx = 64'(cx[it.bb]) - 64'(cx[it.ba]);
        dy = 64'(cy[it.bb]) - 64'(cy[it.ba]);
        rad = 64'(cr[it.ba]) + 64'(cr[it.bb]);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        h = '{tag: it.num, hit: 1'b0, pen: '0, nx: '0, ny: '0, last: it.last};
        if (adx < 64'd2147483648 && ady < 64'd2147483648) begin
            d2 = adx * adx + ady * ady;
            if (d2 < rad * rad) begin
                root_d = int_sqrt(d2 + EPS_Q32);
                pen = $signed(rad) - root_d;
                if (pen > 64'sd2147483647) pen = 64'sd2147483647;
                if (pen < -64'sd2147483648) pen = -64'sd2147483648;
                h.hit = 1'b1;
                h.pen = pen[31:0];
                h.nx = 32'((dx * 64'sd1073741824) / root_d);
                h.ny = 32'((dy * 64'sd1073741824) / root_d);
            end
        end
        expected_hits.push_back(h);
    endtask

    function automatic item_t circle_write(int idx, logic [31:0] x, logic [31:0] y,
                                           logic [29:0] r);
        item_t it;
        it = '{kind: KIND_WRITE, last: 1'($urandom), num: 20'($urandom),
               rad: r, py: y, px: x, bb: 10'($urandom), ba: 10'(idx)};
        loaded[idx] = 1;
        return it;
    endfunction

    function automatic item_t pair_test(int a, int b, int n, bit lst);
        item_t it;
        it = '{kind: KIND_PAIR, last: lst, num: 20'(n), rad: 30'($urandom),
               py: $urandom, px: $urandom, bb: 10'(b), ba: 10'(a)};
        return it;
    endfunction

    function automatic int loaded_body();
        int k;
        do k = $urandom_range(NBODY - 1); while (!loaded[k]);
        return k;
    endfunction

    // Driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_overlap(item_t'({s_tuser, s_tlast, s_tdata[133:0]}));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                    item_t it;
                    it = pending_items.pop_front();
                    s_tdata <= {2'b00, it[133:0]};
                    s_tuser <= it.kind;
                    s_tlast <= it.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                hit_t e;
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("ERROR: unexpected result tag %h",
                                                   m_tdata[19:0]);
                end else begin
                    e = expected_hits.pop_front();
                    if (m_tdata[19:0] !== e.tag || m_tuser !== e.hit ||
                        m_tdata[51:20] !== e.pen || m_tdata[83:52] !== e.nx ||
                        m_tdata[115:84] !== e.ny || m_tlast !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: tag %h hit %b pen %h nx %h ny %h last %b, %s",
                                m_tdata[19:0], m_tuser, m_tdata[51:20], m_tdata[83:52],
                                m_tdata[115:84], m_tlast,
                                $sformatf("expected tag %h hit %b pen %h nx %h ny %h last %b",
                                          e.tag, e.hit, e.pen, e.nx, e.ny, e.last));
                    end
                end
            end
            // Long hold is counted here once requested
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else if (hold_recv) begin
                hold_cycles <= HOLD_LEN;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_sent();
        while (pending_items.size() > 0 || s_tvalid) @(posedge aclk);
    endtask

    task automatic wait_drained();
        wait_sent();
        while (expected_hits.size() > 0) @(posedge aclk);
    endtask

    task automatic add_random(int count);
        int r, a, b;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 25) begin
                a = $urandom_range(NBODY - 1);
                case ($urandom_range(2))
                    0: pending_items.push_back(circle_write(a, $urandom, $urandom,
                                                            30'($urandom)));
                    1: pending_items.push_back(circle_write(a, $urandom_range(400000),
                        $urandom_range(400000), 30'($urandom_range(300000))));
                    default: pending_items.push_back(circle_write(a,
                        32'($signed(-$urandom_range(200000))),
                        32'($signed(-$urandom_range(200000))), 30'($urandom_range(200000))));
                endcase
            end else begin
                a = loaded_body();
                b = (r < 30) ? a : loaded_body();
                pending_items.push_back(pair_test(a, b, $urandom, $urandom_range(15) == 0));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 18; recv_idle = 74;

        // Directed: extremes, identical bodies, far apart, touching, zero radius
        pending_items.push_back(circle_write(0, 32'h8000_0000, 32'h8000_0000, 30'h3FFF_FFFF));
        pending_items.push_back(circle_write(1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 30'h3FFF_FFFF));
        pending_items.push_back(circle_write(1, 0, 0, 30'h1_0000));
        pending_items.push_back(circle_write(2, 32'h1_8000, 0, 30'h8000));
        pending_items.push_back(circle_write(3, 0, 32'h2_0000, 30'h1_0000));
        pending_items.push_back(circle_write(4, 32'hFFFF_0000, 32'hFFFF_8000, 0));
        pending_items.push_back(circle_write(5, 32'h7FFF_FFFF, 32'h8000_0000, 30'h3FFF_FFFF));
        pending_items.push_back(pair_test(0, 1023, 20'hFFFFF, 0));
        pending_items.push_back(pair_test(1023, 0, 0, 1));
        pending_items.push_back(pair_test(0, 0, 1, 0));
        pending_items.push_back(pair_test(4, 4, 2, 0));
        pending_items.push_back(pair_test(1, 2, 3, 0));
        pending_items.push_back(pair_test(1, 3, 4, 0));
        pending_items.push_back(pair_test(2, 1, 5, 0));
        pending_items.push_back(pair_test(1, 4, 6, 0));
        pending_items.push_back(pair_test(0, 5, 7, 0));
        pending_items.push_back(pair_test(5, 1023, 8, 0));
        pending_items.push_back(pair_test(1, 1023, 9, 1));
        for (int k = 6; k < 40; k++)
            pending_items.push_back(circle_write(k, $urandom_range(300000),
                                    $urandom_range(300000), 30'($urandom_range(200000))));
        wait_drained();

        add_random(150);
        wait_sent();

        // Long receiver hold while the sender keeps offering
        hold_recv = 1;
        add_random(150);
        wait (hold_cycles > 0);
        hold_recv = 0;
        wait_drained();

        send_idle = 74; recv_idle = 18;
        add_random(125);
        wait_sent();

        send_idle = 0; recv_idle = 0;
        add_random(125);
        wait_drained();
        repeat (LATENCY) @(posedge aclk);

        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/cpo_pkg.sv
hw/rtl/cpo_sqrt_pipe.sv
hw/rtl/cpo_div_pipe.sv
hw/rtl/circle_pair_overlap_test.sv
test/testbench.sv
